// ===== rtl/core/bied_pkg.sv =====
// Shared types and constants of the banked interrupt enable and dispatch block.
`default_nettype none
package bied_pkg;

	localparam int PEND_W        = 32;
	localparam int IDX_W         = $clog2(PEND_W);
	localparam int IRQ_W         = 7;
	localparam int BASIC_W       = 8;

	localparam logic [BASIC_W-1:0] BASIC_MASK = 8'hFF;

	localparam logic [1:0] CMD_SET      = 2'd0;
	localparam logic [1:0] CMD_CLEAR    = 2'd1;
	localparam logic [1:0] CMD_DISPATCH = 2'd2;

	localparam logic [1:0] BANK_ONE   = 2'd0;
	localparam logic [1:0] BANK_TWO   = 2'd1;
	localparam logic [1:0] BANK_BASIC = 2'd2;

	localparam logic [IRQ_W-1:0] OFFSET_ONE   = 7'd0;
	localparam logic [IRQ_W-1:0] OFFSET_TWO   = 7'(1 << 5);
	localparam logic [IRQ_W-1:0] OFFSET_BASIC = 7'(2 << 5);

	localparam logic [IRQ_W-1:0] IRQ_MAX = 7'd71;

	typedef struct packed {
		logic             start;
		logic [IRQ_W-1:0] base;
	} scan_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/bied_enables.sv =====
// Per-bank enable masks and the masked pending vector for a dispatch.
`default_nettype none
module bied_enables
	import bied_pkg::*;
#(
	parameter int BANK_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [1:0]        command,
	input  wire logic [1:0]        bank,
	input  wire logic [31:0]       write_mask,
	input  wire logic [31:0]       source_lines,
	output logic      [PEND_W-1:0] pend
);

	logic [BANK_WIDTH-1:0] en_one_q;
	logic [BANK_WIDTH-1:0] en_two_q;
	logic [BASIC_W-1:0]    en_basic_q;
	logic [BANK_WIDTH-1:0] wm_bank;
	logic [BASIC_W-1:0]    wm_basic;

	assign wm_bank  = write_mask[BANK_WIDTH-1:0];
	assign wm_basic = write_mask[BASIC_W-1:0] & BASIC_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_one_q   <= '0;
			en_two_q   <= '0;
			en_basic_q <= '0;
		end else if (wr_en) begin
			case (command)
				CMD_SET: begin
					case (bank)
						BANK_ONE:   en_one_q   <= en_one_q | wm_bank;
						BANK_TWO:   en_two_q   <= en_two_q | wm_bank;
						BANK_BASIC: en_basic_q <= en_basic_q | wm_basic;
						default: ;
					endcase
				end
				CMD_CLEAR: begin
					case (bank)
						BANK_ONE:   en_one_q   <= en_one_q & ~wm_bank;
						BANK_TWO:   en_two_q   <= en_two_q & ~wm_bank;
						BANK_BASIC: en_basic_q <= en_basic_q & ~wm_basic;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// unknown bank dispatches nothing
	always_comb begin
		pend = '0;
		case (bank)
			BANK_ONE:   pend[BANK_WIDTH-1:0] = source_lines[BANK_WIDTH-1:0] & en_one_q;
			BANK_TWO:   pend[BANK_WIDTH-1:0] = source_lines[BANK_WIDTH-1:0] & en_two_q;
			BANK_BASIC: pend[BASIC_W-1:0]    = source_lines[BASIC_W-1:0] & en_basic_q;
			default:    pend = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/bied_scan.sv =====
// Bit-serial pending scan with its sequencer and output register.
`default_nettype none
module bied_scan
	import bied_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scan_req_t         req,
	input  wire logic [PEND_W-1:0] pend,
	output logic                   busy,
	output logic                   irq_valid,
	input  wire logic              irq_stall,
	output logic      [IRQ_W-1:0]  irq_number,
	output logic                   last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic [PEND_W-1:0] pend_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IRQ_W-1:0]  base_q;
	logic              ovalid_q;
	logic [IRQ_W-1:0]  onum_q;
	logic              olast_q;

	logic out_free;
	logic hit;
	logic rest_zero;
	logic emit;
	logic advance;

	assign out_free  = !ovalid_q || !irq_stall;
	assign hit       = pend_q[0];
	assign rest_zero = (pend_q[PEND_W-1:1] == '0);
	assign emit      = (state_q == ST_SCAN) && hit && out_free;
	// a set bit holds the scan until the output register can take it
	assign advance   = (state_q == ST_SCAN) && (!hit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (req.start && pend != '0) state_q <= ST_SCAN;
				ST_SCAN: if (advance && rest_zero) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			pend_q <= pend;
			idx_q  <= '0;
			base_q <= req.base;
		end else if (advance) begin
			pend_q <= pend_q >> 1;
			idx_q  <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_free) begin
			ovalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			onum_q  <= base_q + IRQ_W'(idx_q);
			olast_q <= rest_zero;
		end
	end

	assign busy       = (state_q == ST_SCAN);
	assign irq_valid  = ovalid_q;
	assign irq_number = onum_q;
	assign last       = olast_q;

endmodule
`default_nettype wire

// ===== rtl/core/banked_interrupt_enable_dispatch_top.sv =====
// Top level of the banked interrupt enable and dispatch block.
// Three banks of interrupt sources (two of BANK_WIDTH, a basic bank of 8) each
// keep an enable mask. A set or clear word updates the addressed bank's mask in
// the cycle it is taken and yields no result. A dispatch word masks the raw
// request lines with the bank's enables and emits each pending interrupt number
// (bank offset 0, 32 or 64 plus bit), lowest bit first, with last on the final
// one; nothing pending yields nothing. The scan shifts the pending vector one
// bit per cycle unless a set bit waits on a stalled output, and a dispatch holds
// the input while it scans each bit up to and including its highest pending bit
// (at most 32); a finished result may wait in the output register while the
// next word is taken.
`default_nettype none
module banked_interrupt_enable_dispatch_top
	import bied_pkg::*;
#(
	parameter int BANK_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire logic [1:0]       command,
	input  wire logic [1:0]       bank,
	input  wire logic [31:0]      write_mask,
	input  wire logic [31:0]      source_lines,
	output logic                  irq_valid,
	input  wire logic             irq_stall,
	output logic      [IRQ_W-1:0] irq_number,
	output logic                  last
);

	logic              accept;
	logic              busy;
	logic [PEND_W-1:0] pend;
	scan_req_t         req;

	assign item_stall = busy;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		req.start = accept && (command == CMD_DISPATCH);
		case (bank)
			BANK_ONE:   req.base = OFFSET_ONE;
			BANK_TWO:   req.base = OFFSET_TWO;
			BANK_BASIC: req.base = OFFSET_BASIC;
			default:    req.base = OFFSET_ONE;
		endcase
	end

	bied_enables #(
		.BANK_WIDTH(BANK_WIDTH)
	) u_enables (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (accept),
		.command     (command),
		.bank        (bank),
		.write_mask  (write_mask),
		.source_lines(source_lines),
		.pend        (pend)
	);

	bied_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.pend      (pend),
		.busy      (busy),
		.irq_valid (irq_valid),
		.irq_stall (irq_stall),
		.irq_number(irq_number),
		.last      (last)
	);

	// a word that is not last means the scan still holds a pending bit
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		irq_valid && !last |-> busy)
		else $error("non-last word with scan idle");

	a_dispatch_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req.start && (pend != '0) |=> busy)
		else $error("dispatch with pending bits did not start scan");

	a_irq_range: assert property (@(posedge clk) disable iff (!arst_n)
		irq_valid |-> irq_number <= IRQ_MAX)
		else $error("interrupt number out of range");

endmodule
`default_nettype wire

// ===== dv/tb_banked_interrupt_enable_dispatch_top.sv =====
// Testbench for the banked interrupt enable and dispatch block: directed table, then random words.
`default_nettype none
module tb_banked_interrupt_enable_dispatch_top;
	import bied_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [1:0] BANK_UNUSED = 2'd3;
	localparam int PREDICT      = -1;
	localparam int RANDOM_ITEMS = 198;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  bank;
		logic [31:0] mask;
		logic [31:0] lines;
		int          exp_cnt;    // PREDICT, or count of a contiguous run of numbers
		int          exp_first;
	} stim_row_t;

	typedef struct packed {
		logic [IRQ_W-1:0] number;
		logic             last;
	} irq_t;

	// typed rows expect exp_cnt numbers starting at exp_first
	localparam stim_row_t DIRECTED_ROWS [24] = '{
		'{CMD_DISPATCH, BANK_ONE,    32'h0000_0000, 32'hFFFF_FFFF, 0,       0},
		'{CMD_DISPATCH, BANK_BASIC,  32'h0000_0000, 32'hFFFF_FFFF, 0,       0},
		'{CMD_SET,      BANK_ONE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,       0},
		'{CMD_DISPATCH, BANK_ONE,    32'h0000_0000, 32'hFFFF_FFFF, 32,      0},
		'{CMD_DISPATCH, BANK_ONE,    32'hFFFF_FFFF, 32'h0000_0000, 0,       0},
		'{CMD_CLEAR,    BANK_ONE,    32'hFFFF_0000, 32'hFFFF_FFFF, 0,       0},
		'{CMD_DISPATCH, BANK_ONE,    32'h0000_0000, 32'hFFFF_FFFF, 16,      0},
		'{CMD_SET,      BANK_TWO,    32'h8000_0001, 32'h0000_0000, PREDICT, 0},
		'{CMD_DISPATCH, BANK_TWO,    32'h0000_0000, 32'hFFFF_FFFF, PREDICT, 0},
		'{CMD_SET,      BANK_BASIC,  32'hFFFF_FFFF, 32'h0000_0000, 0,       0},
		'{CMD_DISPATCH, BANK_BASIC,  32'h0000_0000, 32'hFFFF_FFFF, 8,       64},
		'{CMD_CLEAR,    BANK_BASIC,  32'hFFFF_FF0F, 32'hFFFF_FFFF, PREDICT, 0},
		'{CMD_DISPATCH, BANK_BASIC,  32'h0000_0000, 32'hFFFF_FFF0, 4,       68},
		'{CMD_SET,      BANK_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,       0},
		'{CMD_DISPATCH, BANK_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,       0},
		'{CMD_UNUSED,   BANK_ONE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,       0},
		'{CMD_DISPATCH, BANK_ONE,    32'h0000_0000, 32'h0000_8000, 1,       15},
		'{CMD_DISPATCH, BANK_TWO,    32'h0000_0000, 32'h5555_5555, PREDICT, 0},
		'{CMD_SET,      BANK_TWO,    32'hAAAA_AAAA, 32'h0000_0000, PREDICT, 0},
		'{CMD_DISPATCH, BANK_TWO,    32'hFFFF_FFFF, 32'hFFFF_FFFF, PREDICT, 0},
		'{CMD_CLEAR,    BANK_TWO,    32'hFFFF_FFFF, 32'h0000_0000, PREDICT, 0},
		'{CMD_DISPATCH, BANK_TWO,    32'h0000_0000, 32'hFFFF_FFFF, 0,       0},
		'{CMD_UNUSED,   BANK_BASIC,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,       0},
		'{CMD_DISPATCH, BANK_ONE,    32'h0000_0000, 32'h0000_0001, 1,       0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	logic [1:0]            command;
	logic [1:0]            bank;
	logic [31:0]           write_mask;
	logic [31:0]           source_lines;
	logic                  irq_valid;
	logic                  irq_stall;
	logic [IRQ_W-1:0]      irq_number;
	logic                  last;

	logic [31:0]           en_one;
	logic [31:0]           en_two;
	logic [7:0]            en_basic;
	irq_t                  irq_expected [$];
	irq_t                  irq_head;
	int                    mismatches;
	int                    quiet_cycles;
	int                    send_idle_pct;
	int                    recv_stall_pct;

	banked_interrupt_enable_dispatch_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.bank         (bank),
		.write_mask   (write_mask),
		.source_lines (source_lines),
		.irq_valid    (irq_valid),
		.irq_stall    (irq_stall),
		.irq_number   (irq_number),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void track_enables(input stim_row_t w);
		if (w.cmd == CMD_SET) begin
			case (w.bank)
				BANK_ONE:   en_one   = en_one | w.mask;
				BANK_TWO:   en_two   = en_two | w.mask;
				BANK_BASIC: en_basic = en_basic | w.mask[7:0];
				default:    ;
			endcase
		end else if (w.cmd == CMD_CLEAR) begin
			case (w.bank)
				BANK_ONE:   en_one   = en_one & ~w.mask;
				BANK_TWO:   en_two   = en_two & ~w.mask;
				BANK_BASIC: en_basic = en_basic & ~w.mask[7:0];
				default:    ;
			endcase
		end
	endfunction

	function automatic void queue_pending_irqs(input stim_row_t w);
		logic [31:0]      pend;
		logic [IRQ_W-1:0] base;
		irq_t             r;
		pend = '0;
		base = OFFSET_ONE;
		if (w.cmd == CMD_DISPATCH) begin
			case (w.bank)
				BANK_ONE:   pend = w.lines & en_one;
				BANK_TWO:   begin pend = w.lines & en_two; base = OFFSET_TWO; end
				BANK_BASIC: begin pend = {24'h0, w.lines[7:0] & en_basic}; base = OFFSET_BASIC; end
				default:    pend = '0;
			endcase
		end
		for (int b = 0; b < 32; b++) begin
			if (pend[b]) begin
				r.number = base + IRQ_W'(b);
				r.last   = ((pend >> b) >> 1) == 32'h0;
				irq_expected.push_back(r);
			end
		end
	endfunction

	function automatic void queue_typed_irqs(input stim_row_t w);
		irq_t r;
		for (int i = 0; i < w.exp_cnt; i++) begin
			r.number = IRQ_W'(w.exp_first + i);
			r.last   = (i == w.exp_cnt - 1);
			irq_expected.push_back(r);
		end
	endfunction

	function automatic logic [31:0] random_bits();
		case ($urandom_range(4))
			0:       return $urandom & $urandom;
			1:       return $urandom | $urandom;
			2:       return 32'h1 << $urandom_range(31);
			3:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic stim_row_t random_word();
		stim_row_t w;
		int        roll;
		roll = $urandom_range(99);
		if (roll < 55)
			w.cmd = CMD_DISPATCH;
		else if (roll < 75)
			w.cmd = CMD_SET;
		else if (roll < 94)
			w.cmd = CMD_CLEAR;
		else
			w.cmd = CMD_UNUSED;
		w.bank      = ($urandom_range(99) < 5) ? BANK_UNUSED : 2'($urandom_range(2));
		w.mask      = random_bits();
		w.lines     = random_bits();
		w.exp_cnt   = PREDICT;
		w.exp_first = 0;
		return w;
	endfunction

	// caller sits just after a rising edge; valid stays high between words unless idling is drawn
	task automatic send_word(input stim_row_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		command      <= w.cmd;
		bank         <= w.bank;
		write_mask   <= w.mask;
		source_lines <= w.lines;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (w.exp_cnt == PREDICT)
			queue_pending_irqs(w);
		else
			queue_typed_irqs(w);
		track_enables(w);
	endtask

	task automatic drain_pause();
		item_valid <= 1'b0;
		@(posedge clk);
		while (irq_expected.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk)
		irq_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && irq_valid && !irq_stall) begin
			if (irq_expected.size() == 0) begin
				report_mismatch($sformatf("irq %0d last %0b with none expected",
					irq_number, last));
			end else begin
				irq_head = irq_expected.pop_front();
				if (irq_number !== irq_head.number)
					report_mismatch($sformatf("irq_number %0d, expected %0d",
						irq_number, irq_head.number));
				if (last !== irq_head.last)
					report_mismatch($sformatf("last %0b on irq %0d, expected %0b",
						last, irq_head.number, irq_head.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (irq_valid && !irq_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_banked_interrupt_enable_dispatch_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t w;
		int        sent;
		arst_n         = 1'b0;
		item_valid     <= 1'b0;
		command        <= CMD_SET;
		bank           <= BANK_ONE;
		write_mask     <= '0;
		source_lines   <= '0;
		irq_stall      <= 1'b0;
		en_one         = '0;
		en_two         = '0;
		en_basic       = '0;
		mismatches     = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 24;
		recv_stall_pct = 49;
		foreach (DIRECTED_ROWS[i])
			send_word(DIRECTED_ROWS[i]);
		drain_pause();

		// three idling profiles
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = (phase == 0) ? 24 : (phase == 1) ? 49 : 0;
			recv_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 24 : 0;
			sent = 0;
			while (sent < RANDOM_ITEMS / 3) begin
				w = random_word();
				send_word(w);
				sent++;
			end
			drain_pause();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && irq_expected.size() == 0)
			$display("tb_banked_interrupt_enable_dispatch_top: PASS");
		else
			$display("tb_banked_interrupt_enable_dispatch_top: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/bied_pkg.sv
rtl/core/bied_enables.sv
rtl/core/bied_scan.sv
rtl/core/banked_interrupt_enable_dispatch_top.sv
dv/tb_banked_interrupt_enable_dispatch_top.sv
